[rtl/core/pct_pkg.sv]
`timescale 1ns / 1ps

package pct_pkg;

  // Field widths.
  localparam int COORD_W = 32;               // signed coordinate
  localparam int SQ_W    = 63;               // unsigned squared quantity
  localparam int DIFF_W  = COORD_W + 1;      // exact coordinate difference
  localparam int PROD_W  = 2 * DIFF_W;       // exact product of two differences
  localparam int DOT_W   = PROD_W + 2;       // signed sum of three products
  localparam int PDSQ_W  = PROD_W + 1;       // unsigned sum of three squares
  localparam int DSQ_W   = PDSQ_W + 1;       // signed pd.pd - quotient
  localparam int NUM_W   = 2 * SQ_W;         // dot * dot
  localparam int QUO_W   = SQ_W;             // quotient bits, one per divider step
  localparam int HALF_W  = 32;               // low half for the split square

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = SQ_W;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_LSQ = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SQ = 3'd7;

  // Data that rides alongside the division unchanged.
  typedef struct packed {
    logic              reject;
    logic [PDSQ_W-1:0] pdsq;
  } pct_side_t;

endpackage

[rtl/core/pct_if.sv]
`timescale 1ns / 1ps

interface pct_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [pct_pkg::COORD_W-1:0]  point_x;
  logic signed [pct_pkg::COORD_W-1:0]  point_y;
  logic signed [pct_pkg::COORD_W-1:0]  point_z;

  modport source (output valid, output point_x, output point_y, output point_z,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input point_z,
                output ready);
endinterface

interface pct_out_if;
  logic                       valid;
  logic                       ready;
  logic                       inside_res;
  logic [pct_pkg::SQ_W-1:0]   dist_sq;

  modport source (output valid, output inside_res, output dist_sq, input ready);
  modport sink (input valid, input inside_res, input dist_sq, output ready);
endinterface

interface pct_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pct_pkg::CFG_IDX_W-1:0]     index;
  logic [pct_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/pct_div.sv]
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage. The caller
// guarantees num < den * 2^QUO_W, so the upper half of the numerator is
// already a valid partial remainder.
module pct_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [pct_pkg::NUM_W-1:0]   num,
  input  logic [pct_pkg::SQ_W-1:0]    den,
  input  pct_pkg::pct_side_t          in_side,
  output logic                        out_valid,
  output logic [pct_pkg::QUO_W-1:0]   quot,
  output pct_pkg::pct_side_t          out_side
);
  import pct_pkg::*;

  localparam int STEPS = QUO_W;

  logic             vld_r  [STEPS];
  logic [SQ_W-1:0]  rem_r  [STEPS];
  logic [QUO_W-1:0] low_r  [STEPS];
  pct_side_t        side_r [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic             vld_in;
    logic [SQ_W-1:0]  rem_in;
    logic [QUO_W-1:0] low_in;
    pct_side_t        side_in;
    logic [SQ_W:0]    trial;
    logic [SQ_W+1:0]  diff;
    logic [SQ_W-1:0]  rem_nxt;
    logic [QUO_W-1:0] low_nxt;

    if (i == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = num[NUM_W-1:QUO_W];
      assign low_in  = num[QUO_W-1:0];
      assign side_in = in_side;
    end else begin : g_rest
      assign vld_in  = vld_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign low_in  = low_r[i-1];
      assign side_in = side_r[i-1];
    end

    // Bring down the next numerator bit and try the subtraction; the sign of
    // the difference is the inverted quotient bit.
    assign trial   = {rem_in, low_in[QUO_W-1]};
    assign diff    = {1'b0, trial} - {2'b00, den};
    assign rem_nxt = diff[SQ_W+1] ? trial[SQ_W-1:0] : diff[SQ_W-1:0];
    assign low_nxt = {low_in[QUO_W-2:0], ~diff[SQ_W+1]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= rem_nxt;
        low_r[i]  <= low_nxt;
        side_r[i] <= side_in;
      end
    end
  end

  assign out_valid = vld_r[STEPS-1];
  assign quot      = low_r[STEPS-1];
  assign out_side  = side_r[STEPS-1];

endmodule

[rtl/core/point_in_cylinder_test_core.sv]
`timescale 1ns / 1ps
// Throughput: one item per cycle while the output does not stall; the 63-stage divider,
// one bit per stage, sets most of the latency.
// A stall on the output freezes the whole pipeline; nothing is lost or repeated.
// Reset (rst_n, synchronous, active low) clears all valid bits and every
// configuration register to zero.

module point_in_cylinder_test_core (
  input  logic       clk,
  input  logic       rst_n,
  pct_in_if.sink     in_if,
  pct_out_if.source  out_if,
  pct_cfg_if.sink    cfg_if
);
  import pct_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes must be issued only with the pipeline empty;
  // the core does not enforce it. Each stage reads these directly, not a copy.
  // ---------------------------------------------------------------------------
  logic signed [COORD_W-1:0] first_x_r, first_y_r, first_z_r;
  logic signed [COORD_W-1:0] second_x_r, second_y_r, second_z_r;
  logic [SQ_W-1:0]           len_sq_r, rad_sq_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_x_r  <= '0;
      first_y_r  <= '0;
      first_z_r  <= '0;
      second_x_r <= '0;
      second_y_r <= '0;
      second_z_r <= '0;
      len_sq_r   <= '0;
      rad_sq_r   <= '0;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_FIRST_X:   first_x_r  <= cfg_if.data[COORD_W-1:0];
        REG_FIRST_Y:   first_y_r  <= cfg_if.data[COORD_W-1:0];
        REG_FIRST_Z:   first_z_r  <= cfg_if.data[COORD_W-1:0];
        REG_SECOND_X:  second_x_r <= cfg_if.data[COORD_W-1:0];
        REG_SECOND_Y:  second_y_r <= cfg_if.data[COORD_W-1:0];
        REG_SECOND_Z:  second_z_r <= cfg_if.data[COORD_W-1:0];
        REG_AXIS_LSQ:  len_sq_r   <= cfg_if.data;
        REG_RADIUS_SQ: rad_sq_r   <= cfg_if.data;
        default: begin
        end
      endcase
    end
  end

  // Axis direction d = P2 - P1, exact in 33 bits.
  logic signed [DIFF_W-1:0] dir_x, dir_y, dir_z;
  assign dir_x = DIFF_W'(second_x_r) - DIFF_W'(first_x_r);
  assign dir_y = DIFF_W'(second_y_r) - DIFF_W'(first_y_r);
  assign dir_z = DIFF_W'(second_z_r) - DIFF_W'(first_z_r);

  // ---------------------------------------------------------------------------
  // Flow control. The pipeline moves as one: it advances whenever the output
  // register is empty or its item is being taken this cycle. Bubbles travel
  // as cleared valid bits.
  // ---------------------------------------------------------------------------
  logic en;
  logic out_valid_r;

  assign en          = !out_valid_r || out_if.ready;
  assign in_if.ready = en;

  // Stage 1: point relative to the first end point.
  logic                     v1_r;
  logic signed [DIFF_W-1:0] pd_x_r, pd_y_r, pd_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pd_x_r <= DIFF_W'(in_if.point_x) - DIFF_W'(first_x_r);
      pd_y_r <= DIFF_W'(in_if.point_y) - DIFF_W'(first_y_r);
      pd_z_r <= DIFF_W'(in_if.point_z) - DIFF_W'(first_z_r);
    end
  end

  // Stage 2: six independent 33x33 signed products, pd*d and pd*pd per axis.
  logic                     v2_r;
  logic signed [PROD_W-1:0] pdd_x_r, pdd_y_r, pdd_z_r;
  logic signed [PROD_W-1:0] pdp_x_r, pdp_y_r, pdp_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pdd_x_r <= pd_x_r * dir_x;
      pdd_y_r <= pd_y_r * dir_y;
      pdd_z_r <= pd_z_r * dir_z;
      pdp_x_r <= pd_x_r * pd_x_r;
      pdp_y_r <= pd_y_r * pd_y_r;
      pdp_z_r <= pd_z_r * pd_z_r;
    end
  end

  // Stage 3: the projection dot = pd.d and the squared length pd.pd.
  logic                     v3_r;
  logic signed [DOT_W-1:0]  dot_r;
  logic [PDSQ_W-1:0]        pdsq3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dot_r   <= DOT_W'(pdd_x_r) + DOT_W'(pdd_y_r) + DOT_W'(pdd_z_r);
      // Squares are never negative, so they zero-extend.
      pdsq3_r <= PDSQ_W'($unsigned(pdp_x_r)) + PDSQ_W'($unsigned(pdp_y_r))
               + PDSQ_W'($unsigned(pdp_z_r));
    end
  end

  // Stage 4: cap tests. A point is rejected when the axis length is zero,
  // when it lies behind the first cap (dot < 0) or beyond the second
  // (dot > L). A rejected item carries a zero projection, which keeps the
  // divider's operands inside its range.
  logic              v4_r;
  logic              rej4_r;
  logic [SQ_W-1:0]   dotu4_r;
  logic [PDSQ_W-1:0] pdsq4_r;
  logic              rej4_nxt;

  assign rej4_nxt = (len_sq_r == '0) || dot_r[DOT_W-1]
                  || (dot_r[DOT_W-2:0] > {{(DOT_W-1-SQ_W){1'b0}}, len_sq_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rej4_r  <= rej4_nxt;
      dotu4_r <= rej4_nxt ? '0 : dot_r[SQ_W-1:0];
      pdsq4_r <= pdsq3_r;
    end
  end

  // Stage 5: dot*dot split into halves, three partial products of at most
  // 32x32 bits. The cross term appears once and is doubled by its shift.
  logic                      v5_r;
  logic                      rej5_r;
  logic [PDSQ_W-1:0]         pdsq5_r;
  logic [2*HALF_W-1:0]       pll_r;
  logic [SQ_W-1:0]           plh_r;
  logic [2*(SQ_W-HALF_W)-1:0] phh_r;
  logic [HALF_W-1:0]         dot_lo;
  logic [SQ_W-HALF_W-1:0]    dot_hi;

  assign dot_lo = dotu4_r[HALF_W-1:0];
  assign dot_hi = dotu4_r[SQ_W-1:HALF_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rej5_r  <= rej4_r;
      pdsq5_r <= pdsq4_r;
      pll_r   <= dot_lo * dot_lo;
      plh_r   <= dot_lo * dot_hi;
      phh_r   <= dot_hi * dot_hi;
    end
  end

  // Stage 6: assemble the 126-bit square.
  logic              v6_r;
  pct_side_t         side6_r;
  logic [NUM_W-1:0]  num6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side6_r.reject <= rej5_r;
      side6_r.pdsq   <= pdsq5_r;
      num6_r <= {phh_r, {(2*HALF_W){1'b0}}}
              + {{(NUM_W-SQ_W-HALF_W-1){1'b0}}, plh_r, {(HALF_W+1){1'b0}}}
              + {{(NUM_W-2*HALF_W){1'b0}}, pll_r};
    end
  end

  // Divider: floor(dot*dot / L). Because dot <= L the quotient fits 63 bits.
  logic             div_valid;
  logic [QUO_W-1:0] div_quot;
  pct_side_t        div_side;

  pct_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v6_r),
    .num       (num6_r),
    .den       (len_sq_r),
    .in_side   (side6_r),
    .out_valid (div_valid),
    .quot      (div_quot),
    .out_side  (div_side)
  );

  // Stage 7: squared distance to the axis, dsq = pd.pd - dot*dot / L.
  logic             v7_r;
  logic             rej7_r;
  logic [DSQ_W-1:0] dsq7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rej7_r <= div_side.reject;
      dsq7_r <= {1'b0, div_side.pdsq} - {{(DSQ_W-QUO_W){1'b0}}, div_quot};
    end
  end

  // Output register: the radius test. A negative distance can only come from
  // an axis length that disagrees with the end points; it is clamped to zero
  // and counted as inside. A distance wider than 63 bits always exceeds R.
  logic            out_inside_r;
  logic [SQ_W-1:0] out_dist_r;
  logic            inside_nxt;
  logic [SQ_W-1:0] dist_nxt;

  always_comb begin
    inside_nxt = 1'b0;
    dist_nxt   = '0;
    if (rej7_r) begin
      inside_nxt = 1'b0;
    end else if (dsq7_r[DSQ_W-1]) begin
      inside_nxt = 1'b1;
    end else if ((|dsq7_r[DSQ_W-2:SQ_W]) || (dsq7_r[SQ_W-1:0] > rad_sq_r)) begin
      inside_nxt = 1'b0;
    end else begin
      inside_nxt = 1'b1;
      dist_nxt   = dsq7_r[SQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_inside_r <= inside_nxt;
      out_dist_r   <= dist_nxt;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.inside_res = out_inside_r;
  assign out_if.dist_sq    = out_dist_r;

endmodule

[test/cylinder_result_checker.sv]
`timescale 1ns / 1ps

module cylinder_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  pct_in_if           in_bus,
  pct_out_if          out_bus,
  pct_cfg_if          cfg_bus,
  output int unsigned mismatch_count,
  output int unsigned verdicts_pending,
  output int unsigned results_checked,
  output int unsigned inside_seen
);
  import pct_pkg::*;

  localparam int REPORT_LIMIT = 40;

  typedef struct packed {
    logic            in_cyl;
    logic [SQ_W-1:0] dist_val;
  } verdict_t;

  // Shadow copy of the cylinder registers, updated on every accepted write.
  logic signed [COORD_W-1:0] axis_first [3];
  logic signed [COORD_W-1:0] axis_second [3];
  logic [SQ_W-1:0]           length_sq;
  logic [SQ_W-1:0]           rad_limit;

  verdict_t verdict_q [$];
  verdict_t want;

  // Exact integer test of one point; 128-bit words hold every intermediate value.
  function automatic verdict_t classify_point(input logic signed [COORD_W-1:0] px,
                                              input logic signed [COORD_W-1:0] py,
                                              input logic signed [COORD_W-1:0] pz);
    logic signed [COORD_W-1:0] pt [3];
    logic signed [127:0]       axis_d, pt_d, dot, pdsq, dsq;
    logic [127:0]              quo;
    verdict_t                  res;
    pt[0] = px;
    pt[1] = py;
    pt[2] = pz;
    dot   = '0;
    pdsq  = '0;
    res   = '0;
    for (int k = 0; k < 3; k++) begin
      axis_d = longint'(axis_second[k]) - longint'(axis_first[k]);
      pt_d   = longint'(pt[k]) - longint'(axis_first[k]);
      dot    = dot + pt_d * axis_d;
      pdsq   = pdsq + pt_d * pt_d;
    end
    if (length_sq == '0) return res;
    if (dot < 0 || dot > $signed({65'd0, length_sq})) return res;
    quo = $unsigned(dot) * $unsigned(dot) / {65'd0, length_sq};
    dsq = pdsq - $signed(quo);
    if (dsq < 0) begin
      // The length register disagrees with the axis; the distance clamps at zero.
      res.in_cyl = 1'b1;
    end else if (dsq <= $signed({65'd0, rad_limit})) begin
      res.in_cyl   = 1'b1;
      res.dist_val = dsq[SQ_W-1:0];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        axis_first[k]  = '0;
        axis_second[k] = '0;
      end
      length_sq = '0;
      rad_limit = '0;
      verdict_q.delete();
      mismatch_count   = 0;
      verdicts_pending = 0;
      results_checked  = 0;
      inside_seen      = 0;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          REG_FIRST_X:   axis_first[0]  = cfg_bus.data[COORD_W-1:0];
          REG_FIRST_Y:   axis_first[1]  = cfg_bus.data[COORD_W-1:0];
          REG_FIRST_Z:   axis_first[2]  = cfg_bus.data[COORD_W-1:0];
          REG_SECOND_X:  axis_second[0] = cfg_bus.data[COORD_W-1:0];
          REG_SECOND_Y:  axis_second[1] = cfg_bus.data[COORD_W-1:0];
          REG_SECOND_Z:  axis_second[2] = cfg_bus.data[COORD_W-1:0];
          REG_AXIS_LSQ:  length_sq      = cfg_bus.data;
          REG_RADIUS_SQ: rad_limit      = cfg_bus.data;
          default: ;
        endcase
      end

      if (out_bus.valid && out_bus.ready) begin
        if (verdict_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: unexpected result, expected none, got inside %0b dist %0d",
                     $time, out_bus.inside_res, out_bus.dist_sq);
        end else begin
          want = verdict_q.pop_front();
          results_checked++;
          if (out_bus.inside_res === 1'b1) inside_seen++;
          if (out_bus.inside_res !== want.in_cyl) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("%0t: inside_res mismatch, expected %0b, got %0b",
                       $time, want.in_cyl, out_bus.inside_res);
          end
          if (out_bus.dist_sq !== want.dist_val) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("%0t: dist_sq mismatch, expected %0d, got %0d",
                       $time, want.dist_val, out_bus.dist_sq);
          end
        end
      end

      if (in_bus.valid && in_bus.ready)
        verdict_q = {verdict_q,
                     classify_point(in_bus.point_x, in_bus.point_y, in_bus.point_z)};

      verdicts_pending = verdict_q.size();
    end
  end

endmodule

[test/point_in_cylinder_test_core_tb.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the point-in-cylinder core. The checker instance
// watches all three channels, predicts each result from its own copy of the
// cylinder registers and counts mismatches; this module only drives items,
// register writes and the result-side ready, then decides pass or fail.
module point_in_cylinder_test_core_tb;
  import pct_pkg::*;

  typedef enum int {
    SHAPE_FIT,        // length register equals the true squared axis length
    SHAPE_SKEWED_LEN, // length register scaled away from the true value
    SHAPE_ZERO_LEN,   // length register cleared, every point must be outside
    SHAPE_NOISE       // every register and coordinate drawn over its full range
  } cyl_shape_t;

  // The run ends far below this limit even with every gap at its longest,
  // so this limit only trips on a hang.
  localparam int CYCLE_LIMIT = 100000;
  // Longer than the pipeline is deep, waited once everything is back.
  localparam int TAIL_CYCLES = 80;
  // Length of the single long receiver stall; far longer than the pipeline.
  localparam int LONG_HOLD   = 300;

  localparam int                        ONE       = 65536;  // 1.0 in Q16.16
  localparam logic [SQ_W-1:0]           SQ_ONE    = 63'd1 << 32;  // 1.0 in Q32.32
  localparam logic [SQ_W-1:0]           SQ_MAX    = {SQ_W{1'b1}};
  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

  logic clk;
  logic rst_n;

  pct_in_if  in_bus ();
  pct_out_if out_bus ();
  pct_cfg_if cfg_bus ();

  int unsigned mismatch_count;
  int unsigned verdicts_pending;
  int unsigned results_checked;
  int unsigned inside_seen;
  int unsigned cycle_count;
  int unsigned points_sent;
  int unsigned settings_loaded;

  // Idling controls shared by the stimulus and the receiver process.
  bit in_burst;
  bit out_burst;
  bit hold_request;

  // The cylinder that the next load writes, and the axis that points are drawn along.
  logic signed [COORD_W-1:0] cyl_first [3];
  logic signed [COORD_W-1:0] cyl_second [3];
  logic [SQ_W-1:0]           cyl_length_sq;
  logic [SQ_W-1:0]           cyl_radius_sq;
  longint                    axis_step [3];
  longint                    spread;

  point_in_cylinder_test_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_bus),
    .out_if (out_bus),
    .cfg_if (cfg_bus)
  );

  cylinder_result_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_bus           (in_bus),
    .out_bus          (out_bus),
    .cfg_bus          (cfg_bus),
    .mismatch_count   (mismatch_count),
    .verdicts_pending (verdicts_pending),
    .results_checked  (results_checked),
    .inside_seen      (inside_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: if the run is still going at the limit, something hung.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run exceeded %0d cycles with %0d results still outstanding.",
             CYCLE_LIMIT, verdicts_pending);
    $display("point_in_cylinder_test_core_tb: FAIL");
    $finish;
  end

  // Result side. For every item the receiver first waits a random number of
  // cycles with ready low, then holds ready high until a result is taken.
  // Once, when the stimulus asks for it, ready stays low for a long stretch
  // so that the pipeline fills completely and the core stalls its input.
  initial begin
    int gap;
    bit hold_done;
    hold_done     = 1'b0;
    out_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        gap       = LONG_HOLD;
      end else begin
        gap = out_burst ? 0 : $urandom_range(0, 10);
      end
      if (gap != 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      @(negedge clk);
    end
  end

  // Offers one point. The random gap comes first; valid stays high between
  // back-to-back items so that it never drops and rises in the same step.
  task automatic send_point(input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y,
                            input logic signed [COORD_W-1:0] z);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.point_x <= x;
    in_bus.point_y <= y;
    in_bus.point_z <= z;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
    points_sent++;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    int gap;
    gap = $urandom_range(0, 10);
    if (gap != 0) begin
      cfg_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= index;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
  endtask

  // Writes every register of the cylinder. Coordinates go out sign-extended
  // to the width of the write port. Only ever called with the core idle.
  task automatic load_cylinder();
    cfg_write(REG_FIRST_X, CFG_DATA_W'(cyl_first[0]));
    cfg_write(REG_FIRST_Y, CFG_DATA_W'(cyl_first[1]));
    cfg_write(REG_FIRST_Z, CFG_DATA_W'(cyl_first[2]));
    cfg_write(REG_SECOND_X, CFG_DATA_W'(cyl_second[0]));
    cfg_write(REG_SECOND_Y, CFG_DATA_W'(cyl_second[1]));
    cfg_write(REG_SECOND_Z, CFG_DATA_W'(cyl_second[2]));
    cfg_write(REG_AXIS_LSQ, cyl_length_sq);
    cfg_write(REG_RADIUS_SQ, cyl_radius_sq);
    cfg_bus.valid <= 1'b0;
    settings_loaded++;
  endtask

  // Stops offering points and waits until every point has its result. Every
  // item yields exactly one result, so an empty store means an idle core.
  task automatic drain();
    in_bus.valid <= 1'b0;
    do @(negedge clk); while (verdicts_pending != 0);
  endtask

  function automatic logic signed [COORD_W-1:0] sat_coord(input longint v);
    if (v > longint'(COORD_MAX)) return COORD_MAX;
    if (v < longint'(COORD_MIN)) return COORD_MIN;
    return COORD_W'(v);
  endfunction

  // One random phase: draw a cylinder of the given shape, load it, then
  // offer points. Most points lie along the axis, from a little behind the
  // first cap to a little past the second, scattered sideways on the scale
  // of the radius, so that inside, cap rejects and radius rejects all occur.
  // The rest are the two cap centers and full-range points, the only kind in noise.
  task automatic run_random_phase(input cyl_shape_t shape, input int count,
                                  input bit pause_midway);
    longint span, start, lsq, t, off;
    int pick;
    logic signed [COORD_W-1:0] pt [3];
    span   = 64'sd1 << $urandom_range(2, 29);
    spread = 64'sd1 << $urandom_range(0, 29);
    lsq    = 0;
    for (int k = 0; k < 3; k++) begin
      axis_step[k]  = longint'($urandom_range(0, 32'(2 * span))) - span;
      start         = longint'($urandom_range(0, 32'h8000_0000)) - 64'sd1073741824;
      cyl_first[k]  = COORD_W'(start);
      cyl_second[k] = COORD_W'(start + axis_step[k]);
      lsq += axis_step[k] * axis_step[k];
    end
    cyl_radius_sq = SQ_W'((spread * spread / 4) * $urandom_range(0, 8));
    case (shape)
      SHAPE_FIT:        cyl_length_sq = SQ_W'(lsq);
      SHAPE_SKEWED_LEN: cyl_length_sq = SQ_W'(lsq / 8 * $urandom_range(1, 16)
                                               + $urandom_range(0, 3));
      SHAPE_ZERO_LEN:   cyl_length_sq = '0;
      default: begin
        for (int k = 0; k < 3; k++) begin
          cyl_first[k]  = $urandom;
          cyl_second[k] = $urandom;
        end
        cyl_length_sq = SQ_W'({$urandom, $urandom});
        cyl_radius_sq = SQ_W'({$urandom, $urandom});
      end
    endcase
    load_cylinder();

    for (int i = 0; i < count; i++) begin
      // Halfway through, the sender may stop until every result is back.
      if (pause_midway && i == count / 2) drain();
      pick = $urandom_range(0, 99);
      if (shape == SHAPE_NOISE || pick < 15) begin
        for (int k = 0; k < 3; k++) pt[k] = $urandom;
      end else if (pick < 22) begin
        for (int k = 0; k < 3; k++) pt[k] = pick[0] ? cyl_first[k] : cyl_second[k];
      end else begin
        t = longint'($urandom_range(0, 1400)) - 200;
        for (int k = 0; k < 3; k++) begin
          off   = longint'($urandom_range(0, 32'(2 * spread))) - spread;
          pt[k] = sat_coord(longint'(cyl_first[k]) + axis_step[k] * t / 1000 + off);
        end
      end
      send_point(pt[0], pt[1], pt[2]);
    end
    drain();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.point_x = '0;
    in_bus.point_y = '0;
    in_bus.point_z = '0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.index  = REG_FIRST_X;
    cfg_bus.data   = '0;
    in_burst       = 1'b0;
    out_burst      = 1'b0;
    hold_request   = 1'b0;
    points_sent    = 0;
    settings_loaded = 0;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Straight out of reset every register is zero, so the axis length is
    // zero and every point must come back outside.
    send_point(0, 0, 0);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX);
    send_point(COORD_MIN, COORD_MIN, COORD_MIN);
    drain();

    // A cylinder along x, 10 units long with radius 2. Points sit on both
    // caps, just behind and beyond them, exactly on the radius and one step
    // past it, and at the corners of the coordinate range.
    cyl_first     = '{32'sd0, 32'sd0, 32'sd0};
    cyl_second    = '{COORD_W'(10 * ONE), 32'sd0, 32'sd0};
    cyl_length_sq = 100 * SQ_ONE;
    cyl_radius_sq = 4 * SQ_ONE;
    load_cylinder();
    send_point(0, 0, 0);
    send_point(10 * ONE, 0, 0);
    send_point(-1, 0, 0);
    send_point(10 * ONE + 1, 0, 0);
    send_point(5 * ONE, 2 * ONE, 0);
    send_point(5 * ONE, 2 * ONE + 1, 0);
    send_point(3 * ONE, -ONE, ONE);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX);
    send_point(COORD_MIN, COORD_MIN, COORD_MIN);
    send_point(COORD_MAX, COORD_MIN, COORD_MAX);
    send_point(COORD_MIN, COORD_MAX, COORD_MIN);
    drain();

    // The length register is set well below the true squared length, so the
    // distance formula goes negative; such points are inside at distance zero.
    cyl_first     = '{COORD_W'(ONE), COORD_W'(ONE), COORD_W'(ONE)};
    cyl_second    = '{COORD_W'(11 * ONE), COORD_W'(ONE), COORD_W'(ONE)};
    cyl_length_sq = 60 * SQ_ONE;
    cyl_radius_sq = 4 * SQ_ONE;
    load_cylinder();
    send_point(6 * ONE, ONE, ONE);
    send_point(ONE, ONE, ONE);
    send_point(7 * ONE, ONE, ONE);
    send_point(7 * ONE + 1, ONE, ONE);
    drain();

    // Full-scale corner with a one-step axis and the largest length and
    // radius. The far corner's distance does not fit in 63 bits and must be
    // rejected; points near the first end point land inside.
    cyl_first     = '{COORD_MIN, COORD_MIN, COORD_MIN};
    cyl_second    = '{COORD_MIN + 1, COORD_MIN, COORD_MIN};
    cyl_length_sq = SQ_MAX;
    cyl_radius_sq = SQ_MAX;
    load_cylinder();
    send_point(COORD_MAX, COORD_MAX, COORD_MAX);
    send_point(COORD_MIN, COORD_MIN, COORD_MIN);
    send_point(COORD_MIN + 1, COORD_MIN, COORD_MIN);
    send_point(COORD_MAX, COORD_MIN, COORD_MIN);
    send_point(COORD_MIN, 0, COORD_MIN);
    drain();

    // Axis across the whole coordinate cube.
    cyl_second = '{COORD_MAX, COORD_MAX, COORD_MAX};
    load_cylinder();
    send_point(COORD_MIN, COORD_MIN, COORD_MIN);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX);
    drain();

    // Random phases. Each draws a fresh cylinder, loaded while idle.
    run_random_phase(SHAPE_FIT, 100, 1'b0);

    // Sender with no gaps while the receiver stalls for a long stretch: the
    // pipeline fills up and the core must hold its input off.
    in_burst     = 1'b1;
    hold_request = 1'b1;
    run_random_phase(SHAPE_FIT, 200, 1'b0);
    in_burst     = 1'b0;

    run_random_phase(SHAPE_SKEWED_LEN, 100, 1'b0);

    // Both sides at full rate, with one pause in the middle that lets the
    // pipeline run completely empty.
    in_burst  = 1'b1;
    out_burst = 1'b1;
    run_random_phase(SHAPE_FIT, 100, 1'b1);
    in_burst  = 1'b0;
    out_burst = 1'b0;

    run_random_phase(SHAPE_ZERO_LEN, 40, 1'b0);
    run_random_phase(SHAPE_NOISE, 100, 1'b0);

    out_burst = 1'b1;
    run_random_phase(SHAPE_FIT, 120, 1'b0);
    out_burst = 1'b0;

    run_random_phase(SHAPE_SKEWED_LEN, 100, 1'b0);

    // Everything is back; a further stretch catches any stray result.
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Covered %0d points over %0d cylinder settings: zero, skewed and full-scale",
             points_sent, settings_loaded);
    $display("axis lengths, a %0d-cycle receiver stall; %0d results, %0d inside, %0d cycles.",
             LONG_HOLD, results_checked, inside_seen, cycle_count);
    if (mismatch_count == 0 && verdicts_pending == 0) begin
      $display("point_in_cylinder_test_core_tb: PASS");
    end else begin
      $display("point_in_cylinder_test_core_tb: FAIL");
    end
    $finish;
  end

endmodule

[point_in_cylinder_test_core.f]
rtl/core/pct_pkg.sv
rtl/core/pct_if.sv
rtl/core/pct_div.sv
rtl/core/point_in_cylinder_test_core.sv
test/cylinder_result_checker.sv
test/point_in_cylinder_test_core_tb.sv
